// File: design/swlt_pkg.sv
`timescale 1ns / 1ps
package swlt_pkg;

  localparam int SEQ_W   = 32;

  localparam logic [2:0] OP_RX     = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_TXDONE = 3'd3;
  localparam logic [2:0] OP_TXFAIL = 3'd4;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [0:0] REG_TRACK_EN = 1'd0;
  localparam logic [0:0] REG_RUN      = 1'd1;

  localparam logic [SEQ_W-1:0] JUMP_LIMIT  = 32'd128;
  localparam logic [SEQ_W-1:0] RETIRE_SPAN = 32'd63;
  localparam logic [SEQ_W-1:0] WINDOW_BITS = 32'd64;
  localparam logic [5:0]       RETIRE_LAST = 6'd62;

  localparam logic [3:0] DP_NOP    = 4'd0;
  localparam logic [3:0] DP_LOAD   = 4'd1;
  localparam logic [3:0] DP_TICK   = 4'd2;
  localparam logic [3:0] DP_CLEAR  = 4'd3;
  localparam logic [3:0] DP_MUL    = 4'd4;
  localparam logic [3:0] DP_TXADD  = 4'd5;
  localparam logic [3:0] DP_TXFAIL = 4'd6;
  localparam logic [3:0] DP_RXHEAD = 4'd7;
  localparam logic [3:0] DP_EVAL   = 4'd8;
  localparam logic [3:0] DP_DRAIN  = 4'd9;
  localparam logic [3:0] DP_RETIRE = 4'd10;
  localparam logic [3:0] DP_JUMP   = 4'd11;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] seq;
    logic [31:0] pkt_run;
    logic        run_present;
    logic [15:0] length;
    logic [15:0] frames;
  } item_t;

  typedef struct packed {
    logic [31:0] interval_index;
    logic [63:0] interval_bytes;
    logic [31:0] tx_done;
    logic [63:0] tx_fail;
    logic [63:0] rx_count;
    logic [63:0] lost_count;
    logic [63:0] dup_count;
    logic [63:0] reorder_count;
  } report_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       run_ok;
    logic       out_busy;
    logic       d_zero;
    logic       d_stale;
    logic       d_big;
    logic       d_ge64;
    logic       map0;
    logic       cnt_last;
  } status_t;

endpackage

// File: design/swlt_if.sv
`timescale 1ns / 1ps
interface swlt_item_if;
  logic            valid;
  logic            ready;
  swlt_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swlt_report_if;
  logic              valid;
  logic              ready;
  swlt_pkg::report_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/swlt_ctrl.sv
`timescale 1ns / 1ps
module swlt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swlt_pkg::status_t status,
  output swlt_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_TXADD  = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_RETIRE = 3'd5;
  localparam logic [2:0] S_JUMP   = 3'd6;

  logic [2:0] state, state_next;
  logic       ret_eval, ret_eval_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ret_eval_next = ret_eval;
    cmd.op        = swlt_pkg::DP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = swlt_pkg::DP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.opcode)
          swlt_pkg::OP_RX: begin
            if (status.run_ok) begin
              cmd.op     = swlt_pkg::DP_RXHEAD;
              state_next = S_EVAL;
            end else begin
              state_next = S_IDLE;
            end
          end
          swlt_pkg::OP_TICK: begin
            if (!status.out_busy) begin
              cmd.op     = swlt_pkg::DP_TICK;
              state_next = S_IDLE;
            end
          end
          swlt_pkg::OP_CLEAR: begin
            cmd.op     = swlt_pkg::DP_CLEAR;
            state_next = S_IDLE;
          end
          swlt_pkg::OP_TXDONE: begin
            cmd.op     = swlt_pkg::DP_MUL;
            state_next = S_TXADD;
          end
          swlt_pkg::OP_TXFAIL: begin
            cmd.op     = swlt_pkg::DP_TXFAIL;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_TXADD: begin
        cmd.op     = swlt_pkg::DP_TXADD;
        state_next = S_IDLE;
      end
      S_EVAL: begin
        cmd.op = swlt_pkg::DP_EVAL;
        if (status.d_zero) begin
          ret_eval_next = 1'b0;
          state_next    = S_DRAIN;
        end else if (status.d_stale) begin
          state_next = S_IDLE;
        end else if (status.d_big) begin
          state_next = S_RETIRE;
        end else if (status.d_ge64) begin
          ret_eval_next = 1'b1;
          state_next    = S_DRAIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DRAIN: begin
        cmd.op = swlt_pkg::DP_DRAIN;
        if (!status.map0) begin
          state_next = ret_eval ? S_EVAL : S_IDLE;
        end
      end
      S_RETIRE: begin
        cmd.op = swlt_pkg::DP_RETIRE;
        if (status.cnt_last) begin
          state_next = S_JUMP;
        end
      end
      S_JUMP: begin
        cmd.op     = swlt_pkg::DP_JUMP;
        state_next = S_EVAL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_eval <= 1'b0;
    end else begin
      state    <= state_next;
      ret_eval <= ret_eval_next;
    end
  end

endmodule

// File: design/swlt_dp.sv
`timescale 1ns / 1ps
module swlt_dp #(
  parameter logic [15:0] FRAME_BYTES = 16'd1536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  swlt_pkg::item_t    in_data,
  output swlt_pkg::report_t  out_data,
  output logic               out_valid,
  input  logic               out_ready,
  input  swlt_pkg::cmd_t     cmd,
  output swlt_pkg::status_t  status
);

  logic        tracking_enable;
  logic [31:0] current_run;
  swlt_pkg::item_t item;

  logic [31:0] expected;
  logic [63:0] early_map;
  logic [63:0] rx_total, lost_total, dup_total, reorder_total, byte_total, tx_fail_total;
  logic [31:0] interval_num, tx_done_total;
  logic [31:0] prod;
  logic [5:0]  cnt;

  logic [31:0] d;
  logic [31:0] run_eff;
  logic [5:0]  bit_idx;
  logic        d_stale;

  assign d       = item.seq - expected;
  assign d_stale = d[31];
  assign run_eff = item.run_present ? item.pkt_run : current_run;
  assign bit_idx = d[5:0] - 6'd1;

  assign status.opcode   = item.opcode;
  assign status.run_ok   = tracking_enable && (run_eff == current_run);
  assign status.out_busy = out_valid && !out_ready;
  assign status.d_zero   = (d == 32'd0);
  assign status.d_stale  = d_stale;
  assign status.d_big    = !d_stale && (d > swlt_pkg::JUMP_LIMIT);
  assign status.d_ge64   = !d_stale && (d >= swlt_pkg::WINDOW_BITS);
  assign status.map0     = early_map[0];
  assign status.cnt_last = (cnt == swlt_pkg::RETIRE_LAST);

  always_ff @(posedge clk) begin
    if (cmd.op == swlt_pkg::DP_LOAD) begin
      item <= in_data;
    end
    if (cmd.op == swlt_pkg::DP_MUL) begin
      prod <= 32'(item.frames) * 32'(FRAME_BYTES);
    end
    if (cmd.op == swlt_pkg::DP_TICK) begin
      out_data.interval_index <= interval_num;
      out_data.interval_bytes <= byte_total;
      out_data.tx_done        <= tx_done_total;
      out_data.tx_fail        <= tx_fail_total;
      out_data.rx_count       <= rx_total;
      out_data.lost_count     <= lost_total;
      out_data.dup_count      <= dup_total;
      out_data.reorder_count  <= reorder_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b0;
      current_run     <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        swlt_pkg::REG_TRACK_EN: tracking_enable <= cfg_data[0];
        swlt_pkg::REG_RUN:      current_run     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == swlt_pkg::DP_TICK) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == swlt_pkg::DP_CLEAR) begin
      expected      <= '0;
      early_map     <= '0;
      rx_total      <= '0;
      lost_total    <= '0;
      dup_total     <= '0;
      reorder_total <= '0;
      byte_total    <= '0;
      interval_num  <= '0;
      tx_done_total <= '0;
      tx_fail_total <= '0;
      cnt           <= '0;
    end else begin
      case (cmd.op)
        swlt_pkg::DP_TICK: begin
          byte_total   <= '0;
          interval_num <= interval_num + 32'd1;
        end
        swlt_pkg::DP_MUL: begin
          tx_done_total <= tx_done_total + {16'd0, item.frames};
        end
        swlt_pkg::DP_TXADD: begin
          byte_total <= byte_total + {32'd0, prod};
        end
        swlt_pkg::DP_TXFAIL: begin
          tx_fail_total <= tx_fail_total + {48'd0, item.frames};
        end
        swlt_pkg::DP_RXHEAD: begin
          rx_total   <= rx_total + 64'd1;
          byte_total <= byte_total + {48'd0, item.length};
        end
        swlt_pkg::DP_EVAL: begin
          if (status.d_zero) begin
            expected <= expected + 32'd1;
          end else if (d_stale) begin
            dup_total <= dup_total + 64'd1;
          end else if (status.d_big) begin
            lost_total <= lost_total + 64'd1;
            expected   <= expected + 32'd1;
            cnt        <= '0;
          end else if (status.d_ge64) begin
            lost_total <= lost_total + 64'd1;
            expected   <= expected + 32'd1;
          end else if (early_map[bit_idx]) begin
            dup_total <= dup_total + 64'd1;
          end else begin
            early_map[bit_idx] <= 1'b1;
            reorder_total      <= reorder_total + 64'd1;
          end
        end
        swlt_pkg::DP_DRAIN: begin
          if (early_map[0]) begin
            expected <= expected + 32'd1;
          end
          early_map <= early_map >> 1;
        end
        swlt_pkg::DP_RETIRE: begin
          if (!early_map[0]) begin
            lost_total <= lost_total + 64'd1;
          end
          expected  <= expected + 32'd1;
          early_map <= early_map >> 1;
          cnt       <= cnt + 6'd1;
        end
        swlt_pkg::DP_JUMP: begin
          early_map  <= '0;
          lost_total <= lost_total + {32'd0, d - swlt_pkg::RETIRE_SPAN};
          expected   <= item.seq - swlt_pkg::RETIRE_SPAN;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/seq_window_loss_tracker.sv
`timescale 1ns / 1ps
// sequence window loss tracker
// items: sink channel of opcode beats (rx packet, tick, clear, tx complete,
//   tx failed); one beat is taken at a time, ready is high only while idle
// reports: source channel, one snapshot beat per tick, held in an output
//   register until taken; beats before the next tick are accepted
// cfg_we / cfg_index / cfg_data: register writes, which the user
//   must make only while idle; the block does not enforce this
// steps per beat: tick, clear, tx failed and ignored packets run
//   at once; tx complete does a 16x16 multiply then a 64-bit add;
//   a stale or out-of-order packet is counted, then evaluated; an
//   in-order packet also drains early arrivals from the window
// a jump beyond 128 adds the one-bit-a-cycle retire walk; catching
//   up over 64..128 adds an eval and a drain walk per lost number
// tick report is valid in the cycle after the tick executes
// a tick that finds the output register still full waits in place
// reset: all counters and the window cleared, tracking off, run id 1,
//   no output valid
module seq_window_loss_tracker #(
  parameter logic [15:0] FRAME_BYTES = 16'd1536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  swlt_item_if.sink   items,
  swlt_report_if.source reports
);

  swlt_pkg::cmd_t    cmd;
  swlt_pkg::status_t status;

  swlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swlt_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (items.data),
    .out_data  (reports.data),
    .out_valid (reports.valid),
    .out_ready (reports.ready),
    .cmd       (cmd),
    .status    (status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("second beat taken while busy");

  a_tick_reports: assert property (@(posedge clk) disable iff (rst)
    cmd.op == swlt_pkg::DP_TICK |=> reports.valid)
    else $error("tick without report");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.op == swlt_pkg::DP_TICK && status.out_busy))
    else $error("report overwritten");

endmodule

// File: bench/swlt_report_checker.sv
`timescale 1ns / 1ps
module swlt_report_checker #(
  parameter logic [15:0] FRAME_BYTES = 16'd1536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  swlt_item_if        items,
  swlt_report_if      reports,
  output int          errors,
  output int          pending,
  output int          reports_checked,
  output int          packets_seen
);

  logic        track_en;
  logic [31:0] run_id;
  logic [31:0] next_seq;
  logic [63:0] early_bits;
  logic [63:0] rx_tot, lost_tot, dup_tot, reord_tot, bytes_tot, txfail_tot;
  logic [31:0] interval_cnt, txdone_tot;
  swlt_pkg::report_t snapshots[$];

  task automatic clear_counters();
    next_seq = '0;
    early_bits = '0;
    rx_tot = '0;
    lost_tot = '0;
    dup_tot = '0;
    reord_tot = '0;
    bytes_tot = '0;
    txfail_tot = '0;
    interval_cnt = '0;
    txdone_tot = '0;
  endtask

  task automatic step_and_drain();
    next_seq = next_seq + 1;
    while (early_bits[0]) begin
      next_seq = next_seq + 1;
      early_bits = early_bits >> 1;
    end
    early_bits = early_bits >> 1;
  endtask

  task automatic track_seq(input logic [31:0] s);
    logic [31:0] d;
    logic [31:0] skip;
    d = s - next_seq;
    if (d == 0) begin
      step_and_drain();
      return;
    end
    if (d[31]) begin
      dup_tot++;
      return;
    end
    if (d > swlt_pkg::JUMP_LIMIT) begin
      lost_tot++;
      next_seq = next_seq + 1;
      for (int i = 0; i < 63; i++) begin
        if (!early_bits[0]) lost_tot++;
        next_seq = next_seq + 1;
        early_bits = early_bits >> 1;
      end
      early_bits = '0;
      skip = (s - next_seq) - swlt_pkg::RETIRE_SPAN;
      lost_tot = lost_tot + {32'd0, skip};
      next_seq = next_seq + skip;
    end
    while (!((s - next_seq) >> 31) && (s - next_seq) >= swlt_pkg::WINDOW_BITS) begin
      lost_tot++;
      step_and_drain();
    end
    d = s - next_seq;
    if (d == 0) begin
      step_and_drain();
    end else if (d <= swlt_pkg::WINDOW_BITS) begin
      if (early_bits[d - 1]) begin
        dup_tot++;
      end else begin
        early_bits[d - 1] = 1'b1;
        reord_tot++;
      end
    end else begin
      dup_tot++;
    end
  endtask

  task automatic predict(input swlt_pkg::item_t it);
    swlt_pkg::report_t r;
    logic [31:0] eff_run;
    case (it.opcode)
      swlt_pkg::OP_RX: begin
        eff_run = it.run_present ? it.pkt_run : run_id;
        if (track_en && eff_run == run_id) begin
          packets_seen++;
          rx_tot++;
          bytes_tot = bytes_tot + {48'd0, it.length};
          track_seq(it.seq);
        end
      end
      swlt_pkg::OP_TICK: begin
        r.interval_index = interval_cnt;
        r.interval_bytes = bytes_tot;
        r.tx_done = txdone_tot;
        r.tx_fail = txfail_tot;
        r.rx_count = rx_tot;
        r.lost_count = lost_tot;
        r.dup_count = dup_tot;
        r.reorder_count = reord_tot;
        snapshots.push_back(r);
        bytes_tot = '0;
        interval_cnt = interval_cnt + 1;
      end
      swlt_pkg::OP_CLEAR: clear_counters();
      swlt_pkg::OP_TXDONE: begin
        txdone_tot = txdone_tot + {16'd0, it.frames};
        bytes_tot = bytes_tot + 64'(it.frames) * 64'(FRAME_BYTES);
      end
      swlt_pkg::OP_TXFAIL: txfail_tot = txfail_tot + {48'd0, it.frames};
      default: ;
    endcase
  endtask

  task automatic cmp_field(input string name, input logic [63:0] exp_v,
                           input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic compare_report(input swlt_pkg::report_t act);
    swlt_pkg::report_t e;
    reports_checked++;
    if (snapshots.size() == 0) begin
      errors++;
      $display("%0t unexpected report beat: expected none actual %h", $time, act);
      return;
    end
    e = snapshots.pop_front();
    cmp_field("interval_index", 64'(e.interval_index), 64'(act.interval_index));
    cmp_field("interval_bytes", e.interval_bytes, act.interval_bytes);
    cmp_field("tx_done", 64'(e.tx_done), 64'(act.tx_done));
    cmp_field("tx_fail", e.tx_fail, act.tx_fail);
    cmp_field("rx_count", e.rx_count, act.rx_count);
    cmp_field("lost_count", e.lost_count, act.lost_count);
    cmp_field("dup_count", e.dup_count, act.dup_count);
    cmp_field("reorder_count", e.reorder_count, act.reorder_count);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    reports_checked = 0;
    packets_seen = 0;
    track_en = 1'b0;
    run_id = 32'd1;
    clear_counters();
  end

  always @(posedge clk) begin
    if (rst) begin
      track_en = 1'b0;
      run_id = 32'd1;
      clear_counters();
      snapshots.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swlt_pkg::REG_TRACK_EN: track_en = cfg_data[0];
          swlt_pkg::REG_RUN: run_id = cfg_data;
          default: ;
        endcase
      end
      if (reports.valid && reports.ready) compare_report(reports.data);
      if (items.valid && items.ready) predict(items.data);
    end
    pending = snapshots.size();
  end
endmodule

// File: bench/seq_window_loss_tracker_tb.sv
`timescale 1ns / 1ps
module seq_window_loss_tracker_tb;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending, reports_checked, packets_seen;
  int          send_idle, recv_idle;
  logic        hold_req;
  logic [31:0] cur_run;
  logic [31:0] seq_base;

  swlt_item_if   item_ch ();
  swlt_report_if report_ch ();

  seq_window_loss_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .reports   (report_ch)
  );

  swlt_report_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .items           (item_ch),
    .reports         (report_ch),
    .errors          (errors),
    .pending         (pending),
    .reports_checked (reports_checked),
    .packets_seen    (packets_seen)
  );

  always #6 clk = ~clk;

  initial begin
    #20ms;
    $display("seq_window_loss_tracker test failed");
    $finish;
  end

  // receiver side, with one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(input swlt_pkg::item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    wait_drained();
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swlt_pkg::REG_RUN) cur_run = val;
  endtask

  function automatic swlt_pkg::item_t mk(input logic [2:0] op, input logic [31:0] s,
                                         input logic rp, input logic [31:0] pr,
                                         input logic [15:0] len, input logic [15:0] fc);
    swlt_pkg::item_t it;
    it.opcode = op;
    it.seq = s;
    it.run_present = rp;
    it.pkt_run = pr;
    it.length = len;
    it.frames = fc;
    return it;
  endfunction

  function automatic swlt_pkg::item_t rand_item();
    swlt_pkg::item_t it;
    int k;
    int pick;
    it = mk(swlt_pkg::OP_RX, 32'd0, 1'b0, $urandom, 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        it.seq = seq_base;
        seq_base++;
      end else if (k < 62) begin
        it.seq = seq_base + $urandom_range(1, 30);
      end else if (k < 70) begin
        it.seq = seq_base + $urandom_range(64, 128);
        seq_base = it.seq + 1;
      end else if (k < 76) begin
        it.seq = seq_base + $urandom_range(129, 5000);
        seq_base = it.seq + 1;
      end else if (k < 80) begin
        it.seq = $urandom;
        seq_base = it.seq + 1;
      end else if (k < 90) begin
        it.seq = seq_base - $urandom_range(1, 1000);
      end else begin
        it.seq = seq_base - $urandom_range(1, 3);
      end
      k = $urandom_range(0, 9);
      if (k < 5) it.run_present = 1'b0;
      else if (k < 8) begin
        it.run_present = 1'b1;
        it.pkt_run = cur_run;
      end else it.run_present = 1'b1;
    end else if (pick < 83) it.opcode = swlt_pkg::OP_TICK;
    else if (pick < 89) it.opcode = swlt_pkg::OP_TXDONE;
    else if (pick < 95) it.opcode = swlt_pkg::OP_TXFAIL;
    else if (pick < 97) begin
      it.opcode = swlt_pkg::OP_CLEAR;
      seq_base = 0;
    end else it.opcode = 3'($urandom_range(swlt_pkg::OP_SPARE_FIRST,
                                           swlt_pkg::OP_SPARE_LAST));
    return it;
  endfunction

  task automatic random_phase(input int n, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      if (r_idle == 77 && i == 40) hold_req <= 1'b1;
      if (i == n / 2) wait_drained();
      send_beat(rand_item());
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    hold_req <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    cur_run = 32'd1;
    seq_base = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(swlt_pkg::REG_TRACK_EN, 32'd1);
    send_beat(mk(swlt_pkg::OP_RX, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd2, 1'b0, 32'd0, 16'd1, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd2, 1'b0, 32'd0, 16'd1, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd1, 1'b1, 32'd1, 16'd2, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd0, 1'b0, 32'd0, 16'd3, 16'd0));
    send_beat(mk(swlt_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd70, 1'b0, 32'd0, 16'hffff, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd135, 1'b0, 32'd0, 16'd5, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd400, 1'b0, 32'd0, 16'd5, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'hffff_ffff, 1'b0, 32'd0, 16'd5, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'h8000_0000, 1'b0, 32'd0, 16'd5, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd7, 1'b1, 32'd2, 16'd9, 16'd0));
    send_beat(mk(swlt_pkg::OP_RX, 32'd7, 1'b1, 32'hffff_ffff, 16'd9, 16'd0));
    send_beat(mk(swlt_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_TXDONE, 32'd0, 1'b0, 32'd0, 16'd0, 16'hffff));
    send_beat(mk(swlt_pkg::OP_TXFAIL, 32'd0, 1'b0, 32'd0, 16'd0, 16'hffff));
    send_beat(mk(swlt_pkg::OP_TXDONE, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_SPARE_FIRST, 32'hffff_ffff, 1'b1, 32'hffff_ffff,
                 16'hffff, 16'hffff));
    send_beat(mk(swlt_pkg::OP_SPARE_MID, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_SPARE_LAST, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_CLEAR, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));
    send_beat(mk(swlt_pkg::OP_TICK, 32'd0, 1'b0, 32'd0, 16'd0, 16'd0));

    write_reg(swlt_pkg::REG_RUN, 32'hffff_ffff);
    random_phase(350, 8, 77);
    write_reg(swlt_pkg::REG_RUN, 32'd0);
    random_phase(350, 77, 8);
    write_reg(swlt_pkg::REG_TRACK_EN, 32'd0);
    random_phase(100, 0, 0);
    write_reg(swlt_pkg::REG_TRACK_EN, 32'd1);
    write_reg(swlt_pkg::REG_RUN, $urandom);
    random_phase(450, 0, 0);

    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d tracked packets and %0d interval reports over four settings",
             packets_seen, reports_checked);
    if (errors == 0) $display("seq_window_loss_tracker test passed");
    else $display("seq_window_loss_tracker test failed");
    $finish;
  end
endmodule
